[rtl/tca_pkg.sv]
`timescale 1ns / 1ps

package tca_pkg;

	// default geometry
	localparam int COORD_BITS_DEF = 12;
	localparam int TAB_CELLS_DEF  = 8;

	localparam int CODE_W  = 16;
	localparam int COLOR_W = 32;
	localparam int CELL_W  = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// character codes with a meaning of their own
	localparam logic [CODE_W-1:0] CODE_NEWLINE = 16'd10;
	localparam logic [CODE_W-1:0] CODE_TAB     = 16'd9;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_READY  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_W = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_H = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR  = 4'd7;

	// register reset values
	localparam int RST_RIGHT  = 1024;
	localparam int RST_BOTTOM = 768;
	localparam logic [CELL_W-1:0]  RST_CELL_W = 8'd8;
	localparam logic [CELL_W-1:0]  RST_CELL_H = 8'd16;
	localparam logic [COLOR_W-1:0] RST_COLOR  = 32'h00FF_FFFF;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_GLYPH,
		KIND_TAB,
		KIND_NEWLINE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] code;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

[rtl/tca_front.sv]
`timescale 1ns / 1ps

module tca_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [tca_pkg::CODE_W-1:0] char_code,
	input  logic                      q_full,
	output logic                      push,
	output tca_pkg::item_t            push_item
);
	import tca_pkg::*;

	logic  v_s1;
	item_t item_s1;
	kind_t kind;
	logic  accept;

	// classify the incoming code
	always_comb begin
		if (char_code == CODE_NEWLINE) begin
			kind = KIND_NEWLINE;
		end else if (char_code == CODE_TAB) begin
			kind = KIND_TAB;
		end else begin
			kind = KIND_GLYPH;
		end
	end

	assign in_stall  = v_s1 & q_full;
	assign accept    = in_valid & ~in_stall;
	assign push      = v_s1 & ~q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind <= kind;
			item_s1.code <= char_code;
		end
	end

endmodule

[rtl/tca_queue.sv]
`timescale 1ns / 1ps

module tca_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tca_pkg::item_t       push_item,
	input  logic                 pop,
	output tca_pkg::item_t       head_item,
	output tca_pkg::queue_stat_t stat
);
	import tca_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign head_item  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/tca_back.sv]
`timescale 1ns / 1ps

module tca_back #(
	parameter int COORD_BITS = tca_pkg::COORD_BITS_DEF,
	parameter int TAB_CELLS  = tca_pkg::TAB_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [tca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tca_pkg::CFG_DATA_W-1:0] cfg_data,
	input  tca_pkg::item_t                head_item,
	input  logic                          q_empty,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          status,
	output logic                          draw_glyph,
	output logic [COORD_BITS-1:0]         glyph_x,
	output logic [COORD_BITS-1:0]         glyph_y,
	output logic [tca_pkg::CODE_W-1:0]     glyph_code,
	output logic [tca_pkg::COLOR_W-1:0]    glyph_color,
	output logic                          scroll_up,
	output logic                          flush_cell
);
	import tca_pkg::*;

	localparam int CB      = COORD_BITS;
	localparam int RW      = CB + 1;
	localparam int SW      = CB + 2;
	localparam int COL_W   = $clog2(TAB_CELLS);
	localparam int CELLS_W = $clog2(TAB_CELLS + 1);
	localparam int PW      = CELLS_W + CELL_W;
	localparam int XW      = ((CB > PW) ? CB : PW) + 1;

	localparam logic [CB-1:0] RIGHT_RST  = CB'(RST_RIGHT);
	localparam logic [CB-1:0] BOTTOM_RST = CB'(RST_BOTTOM);

	// configuration registers
	logic               ready_q;
	logic [CB-1:0]      left_q;
	logic [CB-1:0]      top_q;
	logic [CB-1:0]      right_q;
	logic [CB-1:0]      bottom_q;
	logic [CELL_W-1:0]  cw_q;
	logic [CELL_W-1:0]  ch_q;
	logic [COLOR_W-1:0] color_q;

	// cursor state
	logic [CB-1:0]    cx_q;
	logic [RW-1:0]    cy_q;
	logic [COL_W-1:0] col_q;

	// output word
	logic               ovalid_q;
	logic               status_q;
	logic               draw_q;
	logic [CB-1:0]      gx_q;
	logic [CB-1:0]      gy_q;
	logic [CODE_W-1:0]  gcode_q;
	logic [COLOR_W-1:0] gcolor_q;
	logic               scroll_q;
	logic               flush_q;

	logic               cfg_hit;
	logic [CB-1:0]      home_x;
	logic [CB-1:0]      home_y;

	logic [CELLS_W-1:0] cells;
	logic [PW-1:0]      prod;
	logic [XW-1:0]      x_step;
	logic [XW-1:0]      x_sum;
	logic               wrap;
	logic [SW-1:0]      y_down;
	logic [COL_W-1:0]   col_inc;
	logic [CB-1:0]      nx;
	logic [SW-1:0]      ny;
	logic [COL_W-1:0]   ncol;
	logic               drawn;
	logic               scroll;
	logic [RW-1:0]      ny_fin;

	assign cfg_hit = (cfg_index == CFG_READY)  || (cfg_index == CFG_LEFT)   ||
	                 (cfg_index == CFG_TOP)    || (cfg_index == CFG_RIGHT)  ||
	                 (cfg_index == CFG_BOTTOM) || (cfg_index == CFG_CELL_W) ||
	                 (cfg_index == CFG_CELL_H) || (cfg_index == CFG_COLOR);
	// home to the freshly written edge when that edge is the one written
	assign home_x = (cfg_index == CFG_LEFT) ? cfg_data[CB-1:0] : left_q;
	assign home_y = (cfg_index == CFG_TOP)  ? cfg_data[CB-1:0] : top_q;

	assign pop = ~q_empty & (~ovalid_q | ~out_stall);

	always_comb begin
		cells   = CELLS_W'(TAB_CELLS) - CELLS_W'(col_q);
		prod    = PW'(cells) * PW'(cw_q);
		x_step  = (head_item.kind == KIND_TAB) ? XW'(prod) : XW'(cw_q);
		x_sum   = XW'(cx_q) + x_step;
		wrap    = (x_sum >= XW'(right_q));
		y_down  = SW'(cy_q) + SW'(ch_q);
		col_inc = (col_q == COL_W'(TAB_CELLS - 1)) ? '0 : col_q + 1'b1;

		nx    = left_q;
		ny    = y_down;
		ncol  = '0;
		drawn = 1'b0;
		case (head_item.kind)
			KIND_NEWLINE: begin
				nx = left_q;
				ny = y_down;
			end
			KIND_TAB: begin
				if (!wrap) begin
					nx = x_sum[CB-1:0];
					ny = SW'(cy_q);
				end
			end
			KIND_GLYPH: begin
				drawn = 1'b1;
				if (!wrap) begin
					nx   = x_sum[CB-1:0];
					ny   = SW'(cy_q);
					ncol = col_inc;
				end
			end
			default: begin
				drawn = 1'b0;
			end
		endcase

		// clamp to the last row and ask for a scroll
		scroll = (ny >= SW'(bottom_q));
		if (!scroll) begin
			ny_fin = ny[RW-1:0];
		end else if (bottom_q >= CB'(ch_q)) begin
			ny_fin = RW'(bottom_q - CB'(ch_q));
		end else begin
			ny_fin = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q  <= 1'b0;
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= RIGHT_RST;
			bottom_q <= BOTTOM_RST;
			cw_q     <= RST_CELL_W;
			ch_q     <= RST_CELL_H;
			color_q  <= RST_COLOR;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_READY:  ready_q  <= cfg_data[0];
				CFG_LEFT:   left_q   <= cfg_data[CB-1:0];
				CFG_TOP:    top_q    <= cfg_data[CB-1:0];
				CFG_RIGHT:  right_q  <= cfg_data[CB-1:0];
				CFG_BOTTOM: bottom_q <= cfg_data[CB-1:0];
				CFG_CELL_W: cw_q     <= cfg_data[CELL_W-1:0];
				CFG_CELL_H: ch_q     <= cfg_data[CELL_W-1:0];
				CFG_COLOR:  color_q  <= cfg_data[COLOR_W-1:0];
				default: begin
					ready_q <= ready_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			col_q <= '0;
		end else if (cfg_valid && cfg_hit) begin
			cx_q  <= home_x;
			cy_q  <= RW'(home_y);
			col_q <= '0;
		end else if (pop && ready_q) begin
			cx_q  <= nx;
			cy_q  <= ny_fin;
			col_q <= ncol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (pop) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= ~ready_q;
			draw_q   <= ready_q & drawn;
			gx_q     <= (ready_q && drawn) ? cx_q : '0;
			gy_q     <= (ready_q && drawn) ? cy_q[CB-1:0] : '0;
			gcode_q  <= (ready_q && drawn) ? head_item.code : '0;
			gcolor_q <= (ready_q && drawn) ? color_q : '0;
			scroll_q <= ready_q & scroll;
			flush_q  <= ready_q & drawn & ~scroll;
		end
	end

	assign out_valid   = ovalid_q;
	assign status      = status_q;
	assign draw_glyph  = draw_q;
	assign glyph_x     = gx_q;
	assign glyph_y     = gy_q;
	assign glyph_code  = gcode_q;
	assign glyph_color = gcolor_q;
	assign scroll_up   = scroll_q;
	assign flush_cell  = flush_q;

endmodule

[rtl/text_cursor_advance_core.sv]
`timescale 1ns / 1ps
// Text console cursor engine: one character code in, one result word out.
// Input channel: in_valid / in_stall with char_code. Output channel:
// out_valid / out_stall with status, draw_glyph, glyph_x/y, glyph_code,
// glyph_color, scroll_up and flush_cell. Config channel: cfg_valid /
// cfg_ready with cfg_index and cfg_data; cfg_ready is always high, and
// any write to a known index homes the cursor to the region's top left.
// Path: a word accepted is classified into the front register, then
// enters the two-entry queue and is then shown on the output register.
// Throughput: one word per cycle while out_stall is low; the cursor update (one small multiply
// for tabs, an add and compare for wrap, an add and compare for the
// bottom edge) is combinational in the back stage.
// Reset: display not ready, region 0..1024 x 0..768, 8x16 cells, white
// text, cursor at zero; every word is answered not ready until ready is set.
// Receiver stall: the output word holds, the queue fills, then the front
// register holds and in_stall rises; no word is dropped or repeated.
module text_cursor_advance_core #(
	parameter int COORD_BITS = tca_pkg::COORD_BITS_DEF,
	parameter int TAB_CELLS  = tca_pkg::TAB_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tca_pkg::CODE_W-1:0]     char_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          status,
	output logic                          draw_glyph,
	output logic [COORD_BITS-1:0]         glyph_x,
	output logic [COORD_BITS-1:0]         glyph_y,
	output logic [tca_pkg::CODE_W-1:0]     glyph_code,
	output logic [tca_pkg::COLOR_W-1:0]    glyph_color,
	output logic                          scroll_up,
	output logic                          flush_cell,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tca_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tca_pkg::*;

	logic        push;
	item_t       push_item;
	item_t       head_item;
	logic        pop;
	queue_stat_t q_stat;

	// registers accept every write at once
	assign cfg_ready = 1'b1;

	// front: accept and classify
	tca_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.q_full    (q_stat.full),
		.push      (push),
		.push_item (push_item)
	);

	// decouple front from back
	tca_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.stat      (q_stat)
	);

	// back: advance cursor, build result word
	tca_back #(
		.COORD_BITS (COORD_BITS),
		.TAB_CELLS  (TAB_CELLS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.head_item   (head_item),
		.q_empty     (q_stat.empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.draw_glyph  (draw_glyph),
		.glyph_x     (glyph_x),
		.glyph_y     (glyph_y),
		.glyph_code  (glyph_code),
		.glyph_color (glyph_color),
		.scroll_up   (scroll_up),
		.flush_cell  (flush_cell)
	);

`ifndef SYNTHESIS
	// front holds only when the queue has no room
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled with room in queue");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	// a not-ready word carries nothing else
	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (!draw_glyph && !scroll_up && !flush_cell))
		else $error("not-ready word carries a command");

	// flush only for a drawn cell without scroll
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && flush_cell) |-> (draw_glyph && !scroll_up))
		else $error("flush without draw or during scroll");
`endif

endmodule
